[design/dns_name_decompressor_defines.svh]
// Assertion macros shared by the name decompressor RTL.
`ifndef DNS_NAME_DECOMPRESSOR_DEFINES_SVH
`define DNS_NAME_DECOMPRESSOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DND_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DND_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/dnsdec_pkg.sv]
// Types and constants of the DNS name decompressor.
`default_nettype none
package dnsdec_pkg;

  // Width of a walk offset: a compression pointer carries 14 bits.
  localparam int unsigned POS_W = 14;

  localparam logic CMD_STORE  = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // Register index of hop_limit (address bit 2 of the configuration port)
  localparam logic REG_HOP_LIMIT = 1'b0;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_HOPS  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_LONG  = 2'd3;

  localparam logic [7:0] DOT_CHAR = 8'h2E;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN,
    S_LEN_DATA,
    S_PTR_DATA,
    S_DOT,
    S_LAB,
    S_LAB_DATA,
    S_FINAL
  } dnd_state_t;

endpackage
`default_nettype wire

[design/dns_name_decompressor.sv]
// DNS name decompressor: packet byte store, name walk sequencer and chunk output.
//
// Input channel (in_*): each word is a store or a decode, selected by in_tuser.
// A store writes one packet byte into the internal packet memory; a stream of
// stores loads one byte per cycle while no decode walk runs. A decode walks the
// encoded name at the given offset, following length-prefixed labels and
// compression pointers, and sends the characters on the output channel (out_*)
// in words of eight characters, then one final word (out_tlast high) with the
// remaining 0..7 characters and the status. in_tready is low for the whole walk.
// A length byte is read in S_LEN and S_LEN_DATA, a pointer adds S_PTR_DATA, a
// character passes S_LAB and S_LAB_DATA, and a dot S_DOT; every access goes
// through the single packet memory port with its registered read data, one byte
// per access.
// The output word sits in a register, so the walk keeps going while a word
// waits; when a new word is due and the receiver stalls, the walk holds.
// Configuration (cfg_*, APB): register 0 is hop_limit, reset 255; write it only
// while no decode is running. Reset (rst_n low, synchronous) returns the
// sequencer to idle and drops any pending output word; packet bytes are kept
// and are undefined until written.
`default_nettype none
`include "dns_name_decompressor_defines.svh"
module dns_name_decompressor #(
  parameter int unsigned PACKET_BYTES   = 512,
  parameter int unsigned MAX_NAME_BYTES = 255
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: address [8:0], byte_value [16:9], packet_length [26:17], zero [31:27]
  input  wire logic [31:0] in_tdata,
  // in_tuser: command [0]
  input  wire logic        in_tuser,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: name_chunk [63:0], chunk_bytes [67:64], status [69:68],
  //            name_length [77:70], zero [79:78]
  output logic [79:0]      out_tdata,
  output logic             out_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int unsigned AW = $clog2(PACKET_BYTES);
  localparam int unsigned PW = dnsdec_pkg::POS_W;
  localparam logic [PW:0] PB_LIMIT = (PW + 1)'(PACKET_BYTES);
  localparam logic [7:0]  MAX_LEN  = 8'(MAX_NAME_BYTES);

  // Input word fields
  logic [8:0] in_addr;
  logic [7:0] in_byte;
  logic [9:0] in_plen;
  assign in_addr = in_tdata[8:0];
  assign in_byte = in_tdata[16:9];
  assign in_plen = in_tdata[26:17];

  logic in_fire;
  assign in_fire = in_tvalid && in_tready;

  // Configuration register
  logic [7:0] hop_limit_r;
  logic       cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == dnsdec_pkg::REG_HOP_LIMIT) ? {24'd0, hop_limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hop_limit_r <= 8'd255;
    end else if (cfg_wr && (cfg_paddr[2] == dnsdec_pkg::REG_HOP_LIMIT)) begin
      hop_limit_r <= cfg_pwdata[7:0];
    end
  end

  // Packet memory: one write port from stores, one registered read port for the walk
  logic [7:0]    pkt_mem [PACKET_BYTES];
  logic [7:0]    rd_data_r;
  logic [PW-1:0] rd_pos;
  logic [PW-1:0] st_pos;
  logic          st_ok;

  assign st_pos = PW'(in_addr);
  assign st_ok  = ({1'b0, st_pos} < PB_LIMIT);

  always_ff @(posedge clk) begin
    if (in_fire && (in_tuser == dnsdec_pkg::CMD_STORE) && st_ok) begin
      pkt_mem[st_pos[AW-1:0]] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= pkt_mem[rd_pos[AW-1:0]];
  end

  // Walk state
  dnsdec_pkg::dnd_state_t state_r, state_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] cur_r, cur_nxt;
  logic [6:0]    rem_r, rem_nxt;
  logic [5:0]    hi_r, hi_nxt;
  logic [9:0]    plen_r, plen_nxt;
  logic [7:0]    hop_cnt_r, hop_cnt_nxt;
  logic [7:0]    cnt_r, cnt_nxt;
  logic [63:0]   chunk_r, chunk_nxt;
  logic          first_r, first_nxt;
  logic [1:0]    status_r, status_nxt;

  // Output register
  logic        out_valid_r;
  logic [63:0] out_chunk_r;
  logic [3:0]  out_bytes_r;
  logic        out_last_r;
  logic [1:0]  out_status_r;
  logic [7:0]  out_len_r;

  logic        push;
  logic [63:0] push_chunk;
  logic [3:0]  push_bytes;
  logic        push_last;
  logic [1:0]  push_status;
  logic [7:0]  push_len;

  // Character insert into the chunk being filled
  logic        can_emit;
  logic [7:0]  emit_char;
  logic [63:0] chunk_ins;
  logic [7:0]  cnt_inc;
  logic        chunk_full;
  logic [PW:0] plen_ext;

  assign can_emit   = !out_valid_r || out_tready;
  assign cnt_inc    = cnt_r + 8'd1;
  assign chunk_full = (cnt_inc[2:0] == 3'd0);
  assign emit_char  = (state_r == dnsdec_pkg::S_DOT) ? dnsdec_pkg::DOT_CHAR : rd_data_r;
  assign plen_ext   = (PW + 1)'(plen_r);

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      chunk_ins[k*8 +: 8] = (cnt_r[2:0] == 3'(k)) ? emit_char : chunk_r[k*8 +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= dnsdec_pkg::S_IDLE;
      pos_r     <= '0;
      hop_cnt_r <= '0;
      cnt_r     <= '0;
      chunk_r   <= '0;
      first_r   <= 1'b1;
      status_r  <= dnsdec_pkg::ST_OK;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      hop_cnt_r <= hop_cnt_nxt;
      cnt_r     <= cnt_nxt;
      chunk_r   <= chunk_nxt;
      first_r   <= first_nxt;
      status_r  <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    rem_r  <= rem_nxt;
    hi_r   <= hi_nxt;
    plen_r <= plen_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    cur_nxt     = cur_r;
    rem_nxt     = rem_r;
    hi_nxt      = hi_r;
    plen_nxt    = plen_r;
    hop_cnt_nxt = hop_cnt_r;
    cnt_nxt     = cnt_r;
    chunk_nxt   = chunk_r;
    first_nxt   = first_r;
    status_nxt  = status_r;
    rd_pos      = pos_r;
    push        = 1'b0;
    push_chunk  = chunk_ins;
    push_bytes  = 4'd8;
    push_last   = 1'b0;
    push_status = dnsdec_pkg::ST_OK;
    push_len    = cnt_inc;
    in_tready   = 1'b0;

    unique case (state_r)
      dnsdec_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && (in_tuser == dnsdec_pkg::CMD_DECODE)) begin
          pos_nxt     = PW'(in_addr);
          // clamp the length to the memory size
          plen_nxt    = ((PW + 1)'(in_plen) > PB_LIMIT) ? PB_LIMIT[9:0] : in_plen;
          hop_cnt_nxt = '0;
          cnt_nxt     = '0;
          chunk_nxt   = '0;
          first_nxt   = 1'b1;
          status_nxt  = dnsdec_pkg::ST_OK;
          state_nxt   = dnsdec_pkg::S_LEN;
        end
      end

      dnsdec_pkg::S_LEN: begin
        if ({1'b0, pos_r} >= plen_ext) begin
          status_nxt = dnsdec_pkg::ST_RANGE;
          state_nxt  = dnsdec_pkg::S_FINAL;
        end else begin
          state_nxt = dnsdec_pkg::S_LEN_DATA;
        end
      end

      dnsdec_pkg::S_LEN_DATA: begin
        rd_pos = pos_r + PW'(1);
        if (rd_data_r == 8'd0) begin
          state_nxt = dnsdec_pkg::S_FINAL;
        end else if (rd_data_r[7]) begin
          if (({1'b0, pos_r} + (PW + 1)'(1)) >= plen_ext) begin
            status_nxt = dnsdec_pkg::ST_RANGE;
            state_nxt  = dnsdec_pkg::S_FINAL;
          end else if (hop_cnt_r >= hop_limit_r) begin
            status_nxt = dnsdec_pkg::ST_HOPS;
            state_nxt  = dnsdec_pkg::S_FINAL;
          end else begin
            // fetch the pointer's low byte
            hop_cnt_nxt = hop_cnt_r + 8'd1;
            hi_nxt      = rd_data_r[5:0];
            state_nxt   = dnsdec_pkg::S_PTR_DATA;
          end
        end else begin
          cur_nxt   = pos_r + PW'(1);
          rem_nxt   = rd_data_r[6:0];
          first_nxt = 1'b0;
          state_nxt = first_r ? dnsdec_pkg::S_LAB : dnsdec_pkg::S_DOT;
        end
      end

      dnsdec_pkg::S_PTR_DATA: begin
        pos_nxt   = {hi_r, rd_data_r};
        state_nxt = dnsdec_pkg::S_LEN;
      end

      dnsdec_pkg::S_DOT, dnsdec_pkg::S_LAB_DATA: begin
        rd_pos = cur_r;
        if (cnt_r >= MAX_LEN) begin
          status_nxt = dnsdec_pkg::ST_LONG;
          state_nxt  = dnsdec_pkg::S_FINAL;
        end else if (!chunk_full || can_emit) begin
          cnt_nxt = cnt_inc;
          if (chunk_full) begin
            push      = 1'b1;
            chunk_nxt = '0;
          end else begin
            chunk_nxt = chunk_ins;
          end
          if (state_r == dnsdec_pkg::S_LAB_DATA) begin
            cur_nxt = cur_r + PW'(1);
            rem_nxt = rem_r - 7'd1;
          end
          state_nxt = dnsdec_pkg::S_LAB;
        end
      end

      dnsdec_pkg::S_LAB: begin
        rd_pos = cur_r;
        if (rem_r == 7'd0) begin
          pos_nxt   = cur_r;
          state_nxt = dnsdec_pkg::S_LEN;
        end else if ({1'b0, cur_r} >= plen_ext) begin
          status_nxt = dnsdec_pkg::ST_RANGE;
          state_nxt  = dnsdec_pkg::S_FINAL;
        end else begin
          state_nxt = dnsdec_pkg::S_LAB_DATA;
        end
      end

      dnsdec_pkg::S_FINAL: begin
        push_chunk  = chunk_r;
        push_bytes  = {1'b0, cnt_r[2:0]};
        push_last   = 1'b1;
        push_status = status_r;
        push_len    = cnt_r;
        if (can_emit) begin
          push      = 1'b1;
          chunk_nxt = '0;
          state_nxt = dnsdec_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = dnsdec_pkg::S_IDLE;
      end
    endcase
  end

  // Hold the output word until taken; load a new one when the walk pushes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_chunk_r  <= push_chunk;
      out_bytes_r  <= push_bytes;
      out_last_r   <= push_last;
      out_status_r <= push_status;
      out_len_r    <= push_len;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_len_r, out_status_r, out_bytes_r, out_chunk_r};

  `DND_ASSERT_IMPLY(a_last_partial, clk, rst_n, out_valid_r && out_last_r,
    out_bytes_r[3] == 1'b0, "final word carries more than seven characters")
  `DND_ASSERT_IMPLY(a_mid_full, clk, rst_n, out_valid_r && !out_last_r,
    (out_bytes_r == 4'd8) && (out_status_r == dnsdec_pkg::ST_OK) && (out_len_r[2:0] == 3'd0),
    "intermediate word is not a full, clean chunk")
  `DND_ASSERT_IMPLY(a_len_cap, clk, rst_n, out_valid_r, out_len_r <= MAX_LEN,
    "name length beyond limit")
  `DND_ASSERT_NEXT(a_final_push, clk, rst_n, (state_r == dnsdec_pkg::S_FINAL) && can_emit,
    out_valid_r && out_last_r && (state_r == dnsdec_pkg::S_IDLE),
    "final word not loaded on close")

endmodule
`default_nettype wire
